>>> design/pkl_pkg.sv
// ----------------------------------------------------------------------------
// pkl_pkg: shared types and constants for the peer link keepalive block
// Item layouts, register indexes, configuration and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package pkl_pkg;

    // Address handling: only the low ADDR_BYTES bytes, at most 48 bits, compare
    localparam int ADDR_BYTES = 6;
    localparam int ADDR_W     = 48;
    localparam int USED_BITS  = (8 * ADDR_BYTES > ADDR_W) ? ADDR_W : 8 * ADDR_BYTES;
    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - USED_BITS);
    localparam logic [ADDR_W-1:0] BCAST_ADDR = {ADDR_W{1'b1}};

    localparam logic [7:0] MISS_SAT = 8'hFF;

    // Stream widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 104;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Input item bit positions in s_tdata
    localparam int S_SRC_LSB  = 0;
    localparam int S_RSSI_LSB = 48;
    localparam int S_TAG_LSB  = 56;
    localparam int S_REQ_BIT  = 88;
    localparam int S_TEAM_BIT = 89;

    // Result item bit positions in m_tdata
    localparam int M_TXV_BIT     = 0;
    localparam int M_DEST_LSB    = 1;
    localparam int M_TXREQ_BIT   = 49;
    localparam int M_TXTEAM_BIT  = 50;
    localparam int M_UP_BIT      = 51;
    localparam int M_DOWN_BIT    = 52;
    localparam int M_LINKED_BIT  = 53;
    localparam int M_PARTNER_LSB = 54;

    // Input item kinds (carried in s_tuser)
    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE       = 3'd0,
        REG_OWN_TEAM     = 3'd1,
        REG_RSSI_IDLE    = 3'd2,
        REG_RSSI_LINKED  = 3'd3,
        REG_PING_PERIOD  = 3'd4,
        REG_RETRY_TMO    = 3'd5,
        REG_MAX_RETRIES  = 3'd6,
        REG_EXPECTED_TAG = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic              enable;
        logic              own_blue_team;
        logic signed [7:0] rssi_min_idle;
        logic signed [7:0] rssi_min_linked;
        logic [15:0]       ping_period;
        logic [15:0]       retry_timeout;
        logic [7:0]        max_retries;
        logic [31:0]       expected_tag;
    } cfg_t;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] sender_addr;
        logic signed [7:0] rssi;
        logic [31:0]       frame_tag;
        logic              ping_req;
        logic              peer_blue_team;
    } in_item_t;

    typedef struct packed {
        logic              tx_valid;
        logic [ADDR_W-1:0] tx_dest;
        logic              tx_request;
        logic              tx_blue_team;
        logic              link_up_event;
        logic              link_down_event;
        logic              linked;
        logic [ADDR_W-1:0] partner_addr;
    } result_t;

endpackage

`default_nettype wire

>>> design/pkl_cfg_regs.sv
// ----------------------------------------------------------------------------
// pkl_cfg_regs: configuration register file
// Takes one register write per cycle and presents all settings as a record.
// ----------------------------------------------------------------------------
`default_nettype none

module pkl_cfg_regs
    import pkl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_ENABLE:       cfg_next.enable          = cfg_data[0];
                REG_OWN_TEAM:     cfg_next.own_blue_team   = cfg_data[0];
                REG_RSSI_IDLE:    cfg_next.rssi_min_idle   = cfg_data[7:0];
                REG_RSSI_LINKED:  cfg_next.rssi_min_linked = cfg_data[7:0];
                REG_PING_PERIOD:  cfg_next.ping_period     = cfg_data[15:0];
                REG_RETRY_TMO:    cfg_next.retry_timeout   = cfg_data[15:0];
                REG_MAX_RETRIES:  cfg_next.max_retries     = cfg_data[7:0];
                REG_EXPECTED_TAG: cfg_next.expected_tag    = cfg_data[31:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable          <= 1'b0;
            cfg_reg.own_blue_team   <= 1'b0;
            cfg_reg.rssi_min_idle   <= 8'sh80;
            cfg_reg.rssi_min_linked <= 8'sh80;
            cfg_reg.ping_period     <= 16'd1000;
            cfg_reg.retry_timeout   <= 16'd200;
            cfg_reg.max_retries     <= 8'd3;
            cfg_reg.expected_tag    <= 32'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> design/pkl_engine.sv
// ----------------------------------------------------------------------------
// pkl_engine: link state and per-item decision logic
// Holds the link state; for each item presented it updates the state and
// forms the result in one pass of compares and counter updates.
// ----------------------------------------------------------------------------
`default_nettype none

module pkl_engine
    import pkl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output result_t       result
);

    logic              link_reg,    link_next;
    logic [ADDR_W-1:0] partner_reg, partner_next;
    logic              seen_reg,    seen_next;
    logic [7:0]        miss_reg,    miss_next;
    logic [15:0]       cd_reg,      cd_next;
    logic              started_reg, started_next;

    logic [ADDR_W-1:0] src;
    logic signed [7:0] thr;
    logic              frame_ok;
    logic              same_peer;
    logic [15:0]       cd_dec;
    logic [7:0]        miss_inc;
    logic              fire;
    logic [15:0]       load_raw;

    assign src       = item.sender_addr & ADDR_MASK;
    assign thr       = link_reg ? cfg.rssi_min_linked : cfg.rssi_min_idle;
    assign frame_ok  = ($signed(item.rssi) >= $signed(thr)) &&
                       (item.frame_tag == cfg.expected_tag);
    assign same_peer = (partner_reg == src);
    assign cd_dec    = (cd_reg != 16'd0) ? cd_reg - 16'd1 : 16'd0;
    assign miss_inc  = (miss_reg == MISS_SAT) ? MISS_SAT : miss_reg + 8'd1;

    // Next state and result
    always_comb begin
        link_next    = link_reg;
        partner_next = partner_reg;
        seen_next    = seen_reg;
        miss_next    = miss_reg;
        cd_next      = cd_reg;
        started_next = started_reg;
        fire         = 1'b0;
        load_raw     = 16'd0;
        result       = '0;

        if (!cfg.enable) begin
            // disabled: ticks clear the link, frames do nothing
            if (item.func == FUNC_TICK) begin
                link_next    = 1'b0;
                partner_next = '0;
                miss_next    = 8'd0;
                cd_next      = 16'd0;
                started_next = 1'b0;
            end
        end else if (item.func == FUNC_FRAME) begin
            if (frame_ok) begin
                if (item.ping_req) begin
                    if ((item.peer_blue_team != cfg.own_blue_team) &&
                        (!link_reg || same_peer)) begin
                        result.tx_valid     = 1'b1;
                        result.tx_dest      = src;
                        result.tx_request   = 1'b0;
                        result.tx_blue_team = cfg.own_blue_team;
                    end
                end else if (!link_reg) begin
                    link_next            = 1'b1;
                    seen_next            = 1'b1;
                    miss_next            = 8'd0;
                    partner_next         = src;
                    result.link_up_event = 1'b1;
                end else if (same_peer) begin
                    seen_next = 1'b1;
                    miss_next = 8'd0;
                end
            end
        end else begin
            // tick
            if (!started_reg) begin
                started_next = 1'b1;
                fire         = 1'b1;
            end else begin
                cd_next = cd_dec;
                if (cd_dec == 16'd0) begin
                    fire = 1'b1;
                    if (!seen_reg && link_reg) begin
                        miss_next = miss_inc;
                        if (miss_inc >= cfg.max_retries) begin
                            link_next              = 1'b0;
                            partner_next           = '0;
                            miss_next              = 8'd0;
                            result.link_down_event = 1'b1;
                        end
                    end
                end
            end
            if (fire) begin
                seen_next           = 1'b0;
                result.tx_valid     = 1'b1;
                result.tx_dest      = link_next ? partner_next : BCAST_ADDR;
                result.tx_request   = 1'b1;
                result.tx_blue_team = cfg.own_blue_team;
                load_raw = (miss_next != 8'd0) ? cfg.retry_timeout : cfg.ping_period;
                cd_next  = (load_raw != 16'd0) ? load_raw : 16'd1;
            end
        end

        result.linked       = link_next;
        result.partner_addr = partner_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg    <= 1'b0;
            partner_reg <= '0;
            seen_reg    <= 1'b0;
            miss_reg    <= 8'd0;
            cd_reg      <= 16'd0;
            started_reg <= 1'b0;
        end else if (step) begin
            link_reg    <= link_next;
            partner_reg <= partner_next;
            seen_reg    <= seen_next;
            miss_reg    <= miss_next;
            cd_reg      <= cd_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

>>> design/peer_link_keepalive_top.sv
// ----------------------------------------------------------------------------
// peer_link_keepalive_top: ping-based link keeper with a single peer
// Registers each input item, runs it through the link engine and holds the
// result in an output register until it is taken.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_tvalid/s_tready  | s_tuser func, s_tdata frame fields
//   m_      | out       | m_tvalid/m_tready  | m_tdata result fields
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Each item goes from acceptance into the input register, then through the
// engine into the output register.
// One item is accepted per cycle while the result side keeps taking items.
// A stalled result holds the output register and, behind it, the input register.
// Reset is synchronous and active low; it clears the valid flags and restores config and link defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_link_keepalive_top
    import pkl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [0] func
    input  wire logic                 s_tuser,
    // [47:0] sender_addr, [55:48] rssi, [87:56] frame_tag, [88] ping_req,
    // [89] peer_blue_team, [95:90] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [0] tx_valid, [48:1] tx_dest, [49] tx_request, [50] tx_blue_team,
    // [51] link_up_event, [52] link_down_event, [53] linked,
    // [101:54] partner_addr, [103:102] zero
    output logic [M_TDATA_W-1:0]      m_tdata,
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t     cfg;
    in_item_t in_reg;
    logic     in_valid_reg;
    result_t  res;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     advance;

    pkl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // item moves from input register to output register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    pkl_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (res)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.func           <= s_tuser;
            in_reg.sender_addr    <= s_tdata[S_SRC_LSB +: ADDR_W];
            in_reg.rssi           <= s_tdata[S_RSSI_LSB +: 8];
            in_reg.frame_tag      <= s_tdata[S_TAG_LSB +: 32];
            in_reg.ping_req       <= s_tdata[S_REQ_BIT];
            in_reg.peer_blue_team <= s_tdata[S_TEAM_BIT];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata                               = '0;
        m_tdata[M_TXV_BIT]                    = out_reg.tx_valid;
        m_tdata[M_DEST_LSB +: ADDR_W]         = out_reg.tx_dest;
        m_tdata[M_TXREQ_BIT]                  = out_reg.tx_request;
        m_tdata[M_TXTEAM_BIT]                 = out_reg.tx_blue_team;
        m_tdata[M_UP_BIT]                     = out_reg.link_up_event;
        m_tdata[M_DOWN_BIT]                   = out_reg.link_down_event;
        m_tdata[M_LINKED_BIT]                 = out_reg.linked;
        m_tdata[M_PARTNER_LSB +: ADDR_W]      = out_reg.partner_addr;
    end

endmodule

`default_nettype wire

>>> design/pkl_checker.sv
// ----------------------------------------------------------------------------
// pkl_checker: port-level checks for the peer link keepalive block
// Watches the result channel for consistency of link status and events.
// ----------------------------------------------------------------------------
`default_nettype none

module pkl_checker
    import pkl_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // a result item cannot both raise and drop the link
    a_up_down_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[M_UP_BIT] && m_tdata[M_DOWN_BIT]))
        else $error("link up and down in one item");

    // an up event leaves the link established
    a_up_linked: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[M_UP_BIT]) |-> m_tdata[M_LINKED_BIT])
        else $error("link up event without link");

    // unlinked status always carries a cleared partner
    a_unlinked_partner: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[M_LINKED_BIT]) |->
            (m_tdata[M_PARTNER_LSB +: ADDR_W] == '0))
        else $error("partner set while unlinked");

    // with nothing to send, the transmit fields are zero
    a_no_tx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[M_TXV_BIT]) |->
            (m_tdata[M_DEST_LSB +: ADDR_W] == '0 && !m_tdata[M_TXREQ_BIT] &&
             !m_tdata[M_TXTEAM_BIT]))
        else $error("transmit fields set without a frame");

    // a stalled result stays offered
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result withdrawn while stalled");

endmodule

bind peer_link_keepalive_top pkl_checker u_pkl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> dv/peer_link_keepalive_checker.sv
// ----------------------------------------------------------------------------
// peer_link_keepalive_checker: result predictor and scoreboard
// Watches the config, input and result channels of the keepalive block. It
// keeps its own copy of the registers and the link state, predicts one result
// per accepted input item and compares every accepted result field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module peer_link_keepalive_checker
    import pkl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic                 s_tuser,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output int                        mismatches,
    output int                        pending
);

    // register copy
    logic              run_en;
    logic              own_team;
    logic signed [7:0] idle_floor;
    logic signed [7:0] linked_floor;
    logic [15:0]       ping_ticks;
    logic [15:0]       retry_ticks;
    logic [7:0]        miss_limit;
    logic [31:0]       good_tag;

    // link state copy
    logic              lk_active;
    logic [ADDR_W-1:0] lk_partner;
    logic              lk_reply_seen;
    logic [7:0]        lk_misses;
    logic [15:0]       lk_countdown;
    logic              lk_started;

    result_t expected_link_results[$];
    int      result_no;

    function automatic void drop_link();
        lk_active  = 1'b0;
        lk_partner = '0;
        lk_misses  = '0;
    endfunction

    // Next link result for one input item; updates the state copy
    function automatic result_t predict_link_step(input logic func,
                                                  input logic [S_TDATA_W-1:0] d);
        result_t           r;
        logic [ADDR_W-1:0] src;
        logic signed [7:0] rssi;
        logic signed [7:0] floor_now;
        logic [31:0]       tag;
        logic              req;
        logic              peer_team;
        logic              fire;
        logic [15:0]       reload;
        r         = '0;
        src       = d[S_SRC_LSB +: ADDR_W] & ADDR_MASK;
        rssi      = d[S_RSSI_LSB +: 8];
        tag       = d[S_TAG_LSB +: 32];
        req       = d[S_REQ_BIT];
        peer_team = d[S_TEAM_BIT];
        fire      = 1'b0;
        if (!run_en) begin
            // disabled: frames do nothing, ticks clear everything
            if (func == FUNC_TICK) begin
                drop_link();
                lk_countdown = '0;
                lk_started   = 1'b0;
            end
        end else if (func == FUNC_FRAME) begin
            floor_now = lk_active ? linked_floor : idle_floor;
            if (rssi >= floor_now && tag == good_tag) begin
                if (req) begin
                    if (peer_team != own_team && (!lk_active || lk_partner == src)) begin
                        r.tx_valid     = 1'b1;
                        r.tx_dest      = src;
                        r.tx_request   = 1'b0;
                        r.tx_blue_team = own_team;
                    end
                end else if (!lk_active) begin
                    lk_active       = 1'b1;
                    lk_reply_seen   = 1'b1;
                    lk_misses       = '0;
                    lk_partner      = src;
                    r.link_up_event = 1'b1;
                end else if (lk_partner == src) begin
                    lk_reply_seen = 1'b1;
                    lk_misses     = '0;
                end
            end
        end else begin
            // tick: first one pings at once, later ones count down
            if (!lk_started) begin
                lk_started = 1'b1;
                fire       = 1'b1;
            end else begin
                if (lk_countdown != 0)
                    lk_countdown = lk_countdown - 16'd1;
                if (lk_countdown == 0) begin
                    fire = 1'b1;
                    if (!lk_reply_seen && lk_active) begin
                        if (lk_misses != MISS_SAT)
                            lk_misses = lk_misses + 8'd1;
                        if (lk_misses >= miss_limit) begin
                            drop_link();
                            r.link_down_event = 1'b1;
                        end
                    end
                end
            end
            if (fire) begin
                lk_reply_seen  = 1'b0;
                r.tx_valid     = 1'b1;
                r.tx_dest      = lk_active ? lk_partner : BCAST_ADDR;
                r.tx_request   = 1'b1;
                r.tx_blue_team = own_team;
                reload         = (lk_misses != 0) ? retry_ticks : ping_ticks;
                lk_countdown   = (reload == 0) ? 16'd1 : reload;
            end
        end
        r.linked       = lk_active;
        r.partner_addr = lk_partner;
        return r;
    endfunction

    task automatic check_field(input string fname, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %h, got %h", result_no, fname, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        if (!aresetn) begin
            run_en        = 1'b0;
            own_team      = 1'b0;
            idle_floor    = -8'sd128;
            linked_floor  = -8'sd128;
            ping_ticks    = 16'd1000;
            retry_ticks   = 16'd200;
            miss_limit    = 8'd3;
            good_tag      = '0;
            lk_active     = 1'b0;
            lk_partner    = '0;
            lk_reply_seen = 1'b0;
            lk_misses     = '0;
            lk_countdown  = '0;
            lk_started    = 1'b0;
            expected_link_results.delete();
            result_no     = 0;
            mismatches    = 0;
        end else begin
            // register writes are to land only while the block is idle; the block does not enforce it
            if (cfg_valid && cfg_ready) begin
                case (reg_idx_t'(cfg_index))
                    REG_ENABLE:       run_en       = cfg_data[0];
                    REG_OWN_TEAM:     own_team     = cfg_data[0];
                    REG_RSSI_IDLE:    idle_floor   = cfg_data[7:0];
                    REG_RSSI_LINKED:  linked_floor = cfg_data[7:0];
                    REG_PING_PERIOD:  ping_ticks   = cfg_data[15:0];
                    REG_RETRY_TMO:    retry_ticks  = cfg_data[15:0];
                    REG_MAX_RETRIES:  miss_limit   = cfg_data[7:0];
                    REG_EXPECTED_TAG: good_tag     = cfg_data[31:0];
                    default: ;
                endcase
            end
            // result side first: it always belongs to an older item
            if (m_tvalid && m_tready) begin
                result_no++;
                if (expected_link_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: no item outstanding, got %h",
                                 result_no, m_tdata);
                end else begin
                    want                = expected_link_results.pop_front();
                    got.tx_valid        = m_tdata[M_TXV_BIT];
                    got.tx_dest         = m_tdata[M_DEST_LSB +: ADDR_W];
                    got.tx_request      = m_tdata[M_TXREQ_BIT];
                    got.tx_blue_team    = m_tdata[M_TXTEAM_BIT];
                    got.link_up_event   = m_tdata[M_UP_BIT];
                    got.link_down_event = m_tdata[M_DOWN_BIT];
                    got.linked          = m_tdata[M_LINKED_BIT];
                    got.partner_addr    = m_tdata[M_PARTNER_LSB +: ADDR_W];
                    check_field("tx_valid", ADDR_W'(want.tx_valid), ADDR_W'(got.tx_valid));
                    check_field("tx_dest", want.tx_dest, got.tx_dest);
                    check_field("tx_request", ADDR_W'(want.tx_request),
                                ADDR_W'(got.tx_request));
                    check_field("tx_blue_team", ADDR_W'(want.tx_blue_team),
                                ADDR_W'(got.tx_blue_team));
                    check_field("link_up_event", ADDR_W'(want.link_up_event),
                                ADDR_W'(got.link_up_event));
                    check_field("link_down_event", ADDR_W'(want.link_down_event),
                                ADDR_W'(got.link_down_event));
                    check_field("linked", ADDR_W'(want.linked), ADDR_W'(got.linked));
                    check_field("partner_addr", want.partner_addr, got.partner_addr);
                end
            end
            if (s_tvalid && s_tready)
                expected_link_results.push_back(predict_link_step(s_tuser, s_tdata));
        end
        pending <= expected_link_results.size();
    end

endmodule

>>> dv/peer_link_keepalive_top_test.sv
// ----------------------------------------------------------------------------
// peer_link_keepalive_top_test: stimulus and verdict for the keepalive block
// Runs a short directed sequence through linking, answering, missed replies
// and link loss, then random phases of frames and ticks under changing
// register settings and idle patterns. The checker beside the block does all
// result comparison.
// ----------------------------------------------------------------------------
module peer_link_keepalive_top_test;
    import pkl_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASES         = 8;
    localparam int DISABLED_PHASE = 5;

    localparam logic [ADDR_W-1:0] PEER_A = '1;
    localparam logic [ADDR_W-1:0] PEER_B = '0;
    localparam logic [31:0]       TAG_D  = 32'hA5A5_0F0F;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tuser   = FUNC_FRAME;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_ENABLE;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    wire logic                 s_tready;
    wire logic                 m_tvalid;
    wire logic [M_TDATA_W-1:0] m_tdata;
    wire logic                 cfg_ready;

    int link_errors;
    int link_pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_cnt   = 0;

    // what the stimulus knows of the current settings
    logic              stim_team;
    logic [31:0]       stim_tag;
    int                rssi_floor;
    logic [ADDR_W-1:0] peers[3];

    peer_link_keepalive_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    peer_link_keepalive_checker link_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (link_errors),
        .pending    (link_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // run watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("peer_link_keepalive_top_test NOT OK");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    function automatic logic [S_TDATA_W-1:0] frame_bits(input logic [ADDR_W-1:0] addr,
                                                       input logic [7:0] rssi,
                                                       input logic [31:0] tag,
                                                       input logic req,
                                                       input logic team);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[S_SRC_LSB +: ADDR_W] = addr;
        d[S_RSSI_LSB +: 8]     = rssi;
        d[S_TAG_LSB +: 32]     = tag;
        d[S_REQ_BIT]           = req;
        d[S_TEAM_BIT]          = team;
        return d;
    endfunction

    function automatic int pick_floor();
        case ($urandom_range(3))
            0:       return -128;
            1:       return 127;
            default: return int'($urandom_range(100)) - 90;
        endcase
    endfunction

    // tick counts: zero and full scale now and then, mostly short
    function automatic logic [15:0] pick_ticks();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            default: return 16'($urandom_range(6, 2));
        endcase
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // one item, with random sender gaps in front of it
    task automatic send_item(input logic func, input logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame(input logic [ADDR_W-1:0] addr, input logic [7:0] rssi,
                              input logic [31:0] tag, input logic req, input logic team);
        send_item(FUNC_FRAME, frame_bits(addr, rssi, tag, req, team));
    endtask

    // frame fields ride along with a tick but must not matter
    task automatic send_tick();
        send_item(FUNC_TICK, frame_bits(rand_addr(), 8'($urandom), $urandom,
                                        1'($urandom), 1'($urandom)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (link_pending != 0);
    endtask

    // random settings for one phase; every register gets written
    task automatic program_phase(input int ph);
        int          idle_thr;
        int          linked_thr;
        logic [7:0]  retries;
        idle_thr   = pick_floor();
        linked_thr = pick_floor();
        rssi_floor = (idle_thr > linked_thr) ? idle_thr : linked_thr;
        stim_team  = 1'($urandom);
        case ($urandom_range(3))
            0:       stim_tag = '0;
            1:       stim_tag = '1;
            default: stim_tag = $urandom;
        endcase
        case ($urandom_range(5))
            0:       retries = 8'd0;
            1:       retries = 8'd255;
            2:       retries = 8'd1;
            default: retries = 8'($urandom_range(4, 2));
        endcase
        for (int i = 0; i < 3; i++)
            peers[i] = rand_addr();
        if ($urandom_range(1))
            peers[0] = ($urandom_range(1)) ? PEER_A : PEER_B;
        write_reg(REG_ENABLE, 32'(ph != DISABLED_PHASE));
        write_reg(REG_OWN_TEAM, 32'(stim_team));
        write_reg(REG_RSSI_IDLE, 32'(idle_thr));
        write_reg(REG_RSSI_LINKED, 32'(linked_thr));
        write_reg(REG_PING_PERIOD, 32'(pick_ticks()));
        write_reg(REG_RETRY_TMO, 32'(pick_ticks()));
        write_reg(REG_MAX_RETRIES, 32'(retries));
        write_reg(REG_EXPECTED_TAG, stim_tag);
    endtask

    // mostly well-formed traffic from a small peer set, some noise
    task automatic send_random_item();
        logic [ADDR_W-1:0] addr;
        logic [7:0]        rssi;
        logic [31:0]       tag;
        logic              team;
        if ($urandom_range(99) < 40) begin
            send_tick();
        end else begin
            addr = ($urandom_range(9) == 0) ? rand_addr() : peers[$urandom_range(2)];
            if ($urandom_range(4) == 0)
                rssi = 8'($urandom);
            else
                rssi = 8'(rssi_floor + int'($urandom_range(127 - rssi_floor)));
            tag  = ($urandom_range(7) == 0) ? (stim_tag ^ (32'd1 << $urandom_range(31)))
                                            : stim_tag;
            team = ($urandom_range(3) == 0) ? stim_team : ~stim_team;
            send_frame(addr, rssi, tag, 1'($urandom), team);
        end
    endtask

    initial begin
        tx_idle_pct = 7;
        rx_idle_pct = 70;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // block still disabled after reset
        send_frame(PEER_A, 8'd127, '0, 1'b0, 1'b0);
        send_tick();
        drain();

        // directed: own team blue, peers red
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_OWN_TEAM, 32'd1);
        write_reg(REG_RSSI_IDLE, 32'(-20));
        write_reg(REG_RSSI_LINKED, 32'(-60));
        write_reg(REG_PING_PERIOD, 32'd3);
        write_reg(REG_RETRY_TMO, 32'd2);
        write_reg(REG_MAX_RETRIES, 32'd2);
        write_reg(REG_EXPECTED_TAG, TAG_D);
        send_tick();                                     // first tick pings at once
        send_frame(PEER_A, 8'd127, TAG_D, 1'b1, 1'b0);   // request while unlinked
        send_frame(PEER_A, 8'd127, TAG_D, 1'b1, 1'b1);   // same team, no answer
        send_frame(PEER_A, 8'(-21), TAG_D, 1'b0, 1'b0);  // just under idle floor
        send_frame(PEER_A, 8'd0, ~TAG_D, 1'b0, 1'b0);    // wrong tag
        send_frame(PEER_A, 8'(-20), TAG_D, 1'b0, 1'b1);  // reply links, team ignored
        send_frame(PEER_B, 8'(-128), TAG_D, 1'b0, 1'b0); // weak reply, dropped
        send_frame(PEER_B, 8'd0, TAG_D, 1'b1, 1'b0);     // request from non-partner
        send_frame(PEER_A, 8'(-60), TAG_D, 1'b1, 1'b0);  // partner at linked floor
        send_frame(PEER_A, 8'(-61), TAG_D, 1'b0, 1'b0);  // under linked floor
        repeat (8) send_tick();                          // ping, miss, miss, drop
        drain();

        // zero period, zero timeout, zero retry limit
        write_reg(REG_PING_PERIOD, 32'd0);
        write_reg(REG_RETRY_TMO, 32'd0);
        write_reg(REG_MAX_RETRIES, 32'd0);
        send_frame(PEER_B, 8'd127, TAG_D, 1'b0, 1'b0);
        repeat (4) send_tick();
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph < 3) begin
                tx_idle_pct = 7;
                rx_idle_pct = 70;
            end else if (ph < 6) begin
                tx_idle_pct = 70;
                rx_idle_pct = 7;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            program_phase(ph);
            repeat ((ph == DISABLED_PHASE) ? 30 : 85) send_random_item();
            drain();
        end

        repeat (10) @(posedge aclk);
        if (link_errors == 0 && link_pending == 0)
            $display("peer_link_keepalive_top_test OK");
        else
            $display("peer_link_keepalive_top_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
design/pkl_pkg.sv
design/pkl_cfg_regs.sv
design/pkl_engine.sv
design/peer_link_keepalive_top.sv
design/pkl_checker.sv
dv/peer_link_keepalive_checker.sv
dv/peer_link_keepalive_top_test.sv
